>>> hw/rtl/cdss_pkg.sv
package cdss_pkg;

  localparam int CURVE_TERMS = 11;
  localparam int COEFF_W = 24;
  localparam int Q_W = 18;
  localparam int ACC_W = 40;
  localparam int DIV_W = 36;
  localparam logic signed [Q_W-1:0] Q_MAX = 18'sd131071;
  localparam logic signed [Q_W-1:0] Q_MIN = -18'sd131072;
  localparam logic signed [ACC_W-1:0] ABS_ZERO_Q14 = -40'sd4475290;

  localparam logic [2:0] REG_V_UPPER = 3'd0;
  localparam logic [2:0] REG_V_LOWER = 3'd1;
  localparam logic [2:0] REG_CPV = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_TERMS = 3'd4;
  localparam logic [2:0] REG_TOL = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK0,
    S_DIV,
    S_TERM_INIT,
    S_MUL_T,
    S_MUL_C,
    S_ACC,
    S_DECIDE,
    S_COUNT
  } state_t;

  typedef struct packed {
    logic load;
    logic check0;
    logic div_start;
    logic div_step;
    logic term_init;
    logic mul_t;
    logic mul_c;
    logic acc;
    logic decide;
    logic count;
  } cmd_t;

  typedef struct packed {
    logic miss;
    logic div_done;
    logic last_term;
  } sts_t;

  function automatic logic signed [COEFF_W-1:0] curve_coeff(input logic [3:0] i);
    case (i)
      4'd0: curve_coeff = 24'sd4714607;
      4'd1: curve_coeff = -24'sd3180869;
      4'd2: curve_coeff = -24'sd62880;
      4'd3: curve_coeff = -24'sd21599;
      4'd4: curve_coeff = -24'sd1788;
      4'd5: curve_coeff = -24'sd6443;
      4'd6: curve_coeff = 24'sd2407;
      4'd7: curve_coeff = -24'sd1822;
      4'd8: curve_coeff = 24'sd473;
      4'd9: curve_coeff = -24'sd480;
      4'd10: curve_coeff = 24'sd256;
      default: curve_coeff = '0;
    endcase
  endfunction

  function automatic logic signed [Q_W-1:0] sat18(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(Q_MAX)) sat18 = Q_MAX;
    else if (v < ACC_W'(Q_MIN)) sat18 = Q_MIN;
    else sat18 = v[Q_W-1:0];
  endfunction

endpackage

>>> hw/rtl/chebyshev_diode_setpoint_search_unit.sv
// Bisection search for the 12-bit converter count that puts a silicon-diode
// sensor at temp_setpoint. One item is searched at a time; a finished result
// sits in an output register so the next item can be accepted while it waits.
// Each trial runs a bit-serial divide for x plus setup and decision steps,
// then one multiply/accumulate pass per series term; up to MAX_TRIALS
// trials are run. A new item waits for the search to finish and, if the
// output register is still full, for its beat.
module chebyshev_diode_setpoint_search_unit #(
  parameter int MAX_TRIALS = 30,
  parameter int MAX_TERMS = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic ready_in,
  input  logic signed [13:0] temp_setpoint,
  output logic valid_out,
  input  logic ready_out,
  output logic [11:0] adu_count,
  output logic converged,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data
);

  logic [15:0] v_upper, v_lower;
  logic [19:0] counts_per_volt;
  logic [11:0] count_offset;
  logic [3:0] term_count;
  logic [7:0] tolerance;
  cdss_pkg::cmd_t cmd;
  cdss_pkg::sts_t sts;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_upper <= 16'd32755;
      v_lower <= 16'd2614;
      counts_per_volt <= 20'd349947;
      count_offset <= 12'd2045;
      term_count <= 4'd11;
      tolerance <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        cdss_pkg::REG_V_UPPER: v_upper <= cfg_data[15:0];
        cdss_pkg::REG_V_LOWER: v_lower <= cfg_data[15:0];
        cdss_pkg::REG_CPV: counts_per_volt <= cfg_data;
        cdss_pkg::REG_OFFSET: count_offset <= cfg_data[11:0];
        cdss_pkg::REG_TERMS: term_count <= cfg_data[3:0];
        cdss_pkg::REG_TOL: tolerance <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign ready_in = ~busy;

  cdss_ctrl #(.MAX_TRIALS(MAX_TRIALS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(valid_in & ready_in),
    .out_fire(valid_out & ready_out),
    .sts(sts), .cmd(cmd), .busy(busy), .res_valid(valid_out)
  );

  cdss_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .temp_setpoint(temp_setpoint),
    .v_upper(v_upper), .v_lower(v_lower), .counts_per_volt(counts_per_volt),
    .count_offset(count_offset), .term_count(term_count), .tolerance(tolerance),
    .adu_count(adu_count), .converged(converged)
  );

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(adu_count) && $stable(converged))
    else $error("result beat changed while waiting");
  a_out_after_count: assert property (@(posedge clk) disable iff (rst)
    cmd.count |=> valid_out) else $error("result not presented");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("load without busy");

endmodule

>>> hw/rtl/cdss_ctrl.sv
module cdss_ctrl #(
  parameter int MAX_TRIALS = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  cdss_pkg::sts_t sts,
  output cdss_pkg::cmd_t cmd,
  output logic busy,
  output logic res_valid
);

  localparam int TW = $clog2(MAX_TRIALS + 1);

  cdss_pkg::state_t state, state_next;
  logic [TW-1:0] trials, trials_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdss_pkg::S_IDLE;
      trials <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      trials <= trials_next;
      res_valid <= cmd.count | (res_valid & ~out_fire);
    end
  end

  always_comb begin
    state_next = state;
    trials_next = trials;
    cmd = '0;
    busy = (state != cdss_pkg::S_IDLE);
    case (state)
      cdss_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          trials_next = '0;
          state_next = cdss_pkg::S_CHECK0;
        end
      end
      cdss_pkg::S_CHECK0: begin
        cmd.check0 = 1'b1;
        state_next = cdss_pkg::S_DIV;
      end
      cdss_pkg::S_DIV: begin
        if (!sts.miss || trials == TW'(MAX_TRIALS)) begin
          state_next = cdss_pkg::S_COUNT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = cdss_pkg::S_TERM_INIT;
        end
      end
      cdss_pkg::S_TERM_INIT: begin
        if (sts.div_done) begin
          cmd.term_init = 1'b1;
          state_next = cdss_pkg::S_MUL_T;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      cdss_pkg::S_MUL_T: begin
        cmd.mul_t = 1'b1;
        state_next = cdss_pkg::S_MUL_C;
      end
      cdss_pkg::S_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_next = cdss_pkg::S_ACC;
      end
      cdss_pkg::S_ACC: begin
        cmd.acc = 1'b1;
        state_next = sts.last_term ? cdss_pkg::S_DECIDE : cdss_pkg::S_MUL_T;
      end
      cdss_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        trials_next = trials + 1'b1;
        state_next = cdss_pkg::S_DIV;
      end
      cdss_pkg::S_COUNT: begin
        // wait here while the output register still holds an unaccepted beat
        if (!res_valid || out_fire) begin
          cmd.count = 1'b1;
          state_next = cdss_pkg::S_IDLE;
        end
      end
      default: state_next = cdss_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/cdss_dp.sv
module cdss_dp #(
  parameter int MAX_TERMS = 11
) (
  input  logic clk,
  input  cdss_pkg::cmd_t cmd,
  output cdss_pkg::sts_t sts,
  input  logic signed [13:0] temp_setpoint,
  input  logic [15:0] v_upper,
  input  logic [15:0] v_lower,
  input  logic [19:0] counts_per_volt,
  input  logic [11:0] count_offset,
  input  logic [3:0] term_count,
  input  logic [7:0] tolerance,
  output logic [11:0] adu_count,
  output logic converged
);

  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam int QW = cdss_pkg::Q_W;
  localparam int AW = cdss_pkg::ACC_W;
  localparam int DW = cdss_pkg::DIV_W;

  logic signed [AW-1:0] target, acc;
  logic [15:0] lower, upper, vmid;
  logic miss;
  logic signed [QW-1:0] x, t0, t1;
  logic [NW-1:0] idx, n_eff;
  logic signed [QW+QW-1:0] prod_t;
  logic signed [cdss_pkg::COEFF_W+QW-1:0] prod_c;
  logic [DW-1:0] rem, quo, dvs;
  logic num_neg, den_neg, den_zero;
  logic [5:0] dcnt;
  logic [11:0] count_r;
  logic conv_r;

  logic signed [AW-1:0] diff, tol_s, t_cmp;
  logic off;
  logic signed [17:0] den_s, num_s;
  logic [DW:0] rem_sh;
  logic signed [AW-1:0] qs, t2w;
  logic signed [cdss_pkg::COEFF_W-1:0] coeff;
  logic [35:0] scaled;

  always_comb begin
    if (term_count < 4'd2) n_eff = NW'(2);
    else if ({{(NW > 4 ? NW - 4 : 0){1'b0}}, term_count} > NW'(MAX_TERMS))
      n_eff = NW'(MAX_TERMS);
    else n_eff = NW'(term_count);
  end

  assign coeff = (idx < NW'(cdss_pkg::CURVE_TERMS)) ?
                 cdss_pkg::curve_coeff(4'(idx)) : '0;
  assign tol_s = AW'($signed({1'b0, tolerance, 10'd0}));
  assign t_cmp = cmd.check0 ? cdss_pkg::ABS_ZERO_Q14 : acc;
  assign diff = t_cmp - target;
  assign off = (diff < 0 ? -diff : diff) > tol_s;
  assign den_s = $signed({2'b00, v_upper}) - $signed({2'b00, v_lower});
  assign num_s = $signed({1'b0, vmid, 1'b0}) - $signed({2'b00, v_lower}) -
                 $signed({2'b00, v_upper});
  assign rem_sh = {rem, quo[DW-1]};
  assign qs = num_neg ^ den_neg ? -AW'($signed({1'b0, quo})) : AW'($signed({1'b0, quo}));
  assign t2w = AW'(prod_t >>> 16) * 2 - AW'(t0);
  assign scaled = 36'(vmid) * 36'(counts_per_volt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= AW'(temp_setpoint) <<< 10;
      lower <= v_lower;
      upper <= v_upper;
      vmid <= 16'((17'(v_lower) + 17'(v_upper)) >> 1);
    end
    if (cmd.check0 || cmd.decide) begin
      miss <= off;
    end
    if (cmd.div_start) begin
      num_neg <= num_s[17];
      den_neg <= den_s[17];
      den_zero <= (den_s == '0);
      quo <= DW'(num_s[17] ? 18'(-num_s) : 18'(num_s)) << 16;
      dvs <= DW'(den_s[17] ? 18'(-den_s) : 18'(den_s));
      rem <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DW'(rem_sh - {1'b0, dvs});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= DW'(rem_sh);
        quo <= {quo[DW-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.term_init) begin
      x <= den_zero ? '0 : cdss_pkg::sat18(qs);
      t0 <= QW'(65536);
      t1 <= den_zero ? '0 : cdss_pkg::sat18(qs);
      idx <= '0;
      acc <= cdss_pkg::ABS_ZERO_Q14;
    end
    if (cmd.mul_t) begin
      prod_t <= x * t1;
      prod_c <= coeff * (idx == '0 ? t0 : t1);
    end
    if (cmd.mul_c) begin
      acc <= acc + AW'(prod_c >>> 16);
    end
    if (cmd.acc) begin
      if (idx != '0) begin
        t0 <= t1;
        t1 <= cdss_pkg::sat18(t2w);
      end
      idx <= idx + 1'b1;
    end
    if (cmd.decide) begin
      if (off) begin
        if (acc < target) begin
          upper <= vmid;
          vmid <= 16'((17'(lower) + 17'(vmid)) >> 1);
        end else begin
          lower <= vmid;
          vmid <= 16'((17'(vmid) + 17'(upper)) >> 1);
        end
      end
    end
    if (cmd.count) begin
      count_r <= 12'(scaled >> 23) + count_offset;
      conv_r <= ~miss;
    end
  end

  assign sts.miss = miss;
  assign sts.div_done = (dcnt == 6'(DW));
  assign sts.last_term = (idx == n_eff - 1'b1);
  assign adu_count = count_r;
  assign converged = conv_r;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int TRIAL_LIMIT = 30;
  localparam int TERM_LIMIT = 11;
  localparam int WATCHDOG_CYCLES = 40000;
  localparam int SETTLE_CYCLES = 2500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic ready_in;
  logic signed [13:0] temp_setpoint = '0;
  logic valid_out;
  logic ready_out = 1'b0;
  logic [11:0] adu_count;
  logic converged;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  typedef struct {
    logic [11:0] count;
    logic conv;
  } setpoint_t;

  setpoint_t pending_setpoints[$];

  // predictor copy of the configuration
  logic [15:0] m_v_upper, m_v_lower;
  logic [19:0] m_cpv;
  logic [11:0] m_offset;
  logic [3:0] m_terms;
  logic [7:0] m_tol;
  logic signed [23:0] m_coeff[TERM_LIMIT];

  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit rx_idle_enable = 1;
  bit tx_idle_enable = 1;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_off = 0;

  chebyshev_diode_setpoint_search_unit DUT (
    .clk(clk), .rst(rst),
    .valid_in(valid_in), .ready_in(ready_in),
    .temp_setpoint(temp_setpoint),
    .valid_out(valid_out), .ready_out(ready_out),
    .adu_count(adu_count), .converged(converged),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_q216(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint diode_temp(logic [15:0] v);
    longint vu, vl, den, num, x, t0, t1, t2, acc;
    int n;
    vu = m_v_upper;
    vl = m_v_lower;
    den = vu - vl;
    num = 2 * longint'(v) - vl - vu;
    x = 0;
    if (den != 0) x = clamp_q216((num * 65536) / den);
    n = m_terms;
    if (n < 2) n = 2;
    if (n > TERM_LIMIT) n = TERM_LIMIT;
    t0 = 65536;
    t1 = x;
    acc = -4475290;
    acc += fdiv(longint'(m_coeff[0]) * t0, 16);
    acc += fdiv(longint'(m_coeff[1]) * t1, 16);
    for (int i = 2; i < n; i++) begin
      t2 = clamp_q216(2 * fdiv(x * t1, 16) - t0);
      acc += fdiv(longint'(m_coeff[i]) * t2, 16);
      t0 = t1;
      t1 = t2;
    end
    return acc;
  endfunction

  function automatic bit off_target(longint t, longint tgt);
    longint d;
    d = t - tgt;
    if (d < 0) d = -d;
    return d > longint'(m_tol) * 1024;
  endfunction

  function automatic setpoint_t search_setpoint(logic signed [13:0] temp);
    setpoint_t r;
    longint tgt, t;
    logic [16:0] lo, hi, mid;
    bit miss;
    longint scaled;
    tgt = longint'(temp) * 1024;
    lo = m_v_lower;
    hi = m_v_upper;
    mid = (lo + hi) >> 1;
    miss = off_target(-4475290, tgt);
    for (int k = 0; k < TRIAL_LIMIT && miss; k++) begin
      t = diode_temp(mid[15:0]);
      miss = off_target(t, tgt);
      if (miss) begin
        if (t < tgt) hi = mid;
        else lo = mid;
        mid = (lo + hi) >> 1;
      end
    end
    scaled = (longint'(mid) * longint'(m_cpv)) >> 23;
    r.count = 12'(scaled + m_offset);
    r.conv = !miss;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cdss_pkg::REG_V_UPPER: m_v_upper = val[15:0];
      cdss_pkg::REG_V_LOWER: m_v_lower = val[15:0];
      cdss_pkg::REG_CPV: m_cpv = val;
      cdss_pkg::REG_OFFSET: m_offset = val[11:0];
      cdss_pkg::REG_TERMS: m_terms = val[3:0];
      cdss_pkg::REG_TOL: m_tol = val[7:0];
      default: ;
    endcase
  endtask

  // valid stays up between beats unless an idle gap is drawn
  task automatic send_target(logic signed [13:0] temp);
    int gap;
    if (tx_idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      valid_in <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid_in <= 1'b1;
    temp_setpoint <= temp;
    pending_setpoints.push_back(search_setpoint(temp));
    do @(posedge clk); while (!ready_in);
  endtask

  task automatic drain;
    valid_in <= 1'b0;
    while (pending_setpoints.size() != 0 && !timed_out) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [13:0] rand_target();
    return 14'($urandom_range(0, 8466)) - 14'sd4371;
  endfunction

  // output side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      ready_out <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 6000;
      ready_out <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      ready_out <= 1'b0;
    end else if (rx_idle_enable && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 8);
      ready_out <= 1'b0;
    end else begin
      ready_out <= 1'b1;
    end
  end

  always @(posedge clk) begin
    setpoint_t exp_sp;
    if (!rst && valid_out && ready_out) begin
      if (pending_setpoints.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: count=%0d conv=%0b",
          adu_count, converged);
      end else begin
        exp_sp = pending_setpoints.pop_front();
        if (adu_count !== exp_sp.count || converged !== exp_sp.conv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp count=%0d conv=%0b got count=%0d conv=%0b",
              exp_sp.count, exp_sp.conv, adu_count, converged);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (valid_in && ready_in) || (valid_out && ready_out)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed;
    logic signed [13:0] temps[12];
    temps = '{-14'sd4371, 14'sd4095, -14'sd4370, -14'sd4360, 14'sd0, -14'sd1,
              -14'sd4369, 14'sd1234, -14'sd3200, 14'sd16, 14'sd5461,
              -14'sd2731};
    foreach (temps[i]) begin
      if (temps[i] >= -14'sd4371) send_target(temps[i]);
    end
    send_target(14'sd4095);
    drain();
  endtask

  task automatic test_config_corners;
    // equal limits, few terms, zero tolerance
    write_reg(cdss_pkg::REG_V_UPPER, 20'd20000);
    write_reg(cdss_pkg::REG_V_LOWER, 20'd20000);
    write_reg(cdss_pkg::REG_TERMS, 20'd0);
    write_reg(cdss_pkg::REG_TOL, 20'd0);
    for (int i = 0; i < 6; i++) send_target(rand_target());
    send_target(-14'sd4371);
    drain();
    // swapped limits, overflowing count, too many terms, wide tolerance
    write_reg(cdss_pkg::REG_V_UPPER, 20'd0);
    write_reg(cdss_pkg::REG_V_LOWER, 20'hFFFF);
    write_reg(cdss_pkg::REG_CPV, 20'hFFFFF);
    write_reg(cdss_pkg::REG_OFFSET, 20'hFFF);
    write_reg(cdss_pkg::REG_TERMS, 20'd15);
    write_reg(cdss_pkg::REG_TOL, 20'd255);
    write_reg(3'd6, 20'hABCDE);
    write_reg(3'd7, 20'h12345);
    for (int i = 0; i < 6; i++) send_target(rand_target());
    drain();
    // zero scale, full range limits
    write_reg(cdss_pkg::REG_V_UPPER, 20'hFFFF);
    write_reg(cdss_pkg::REG_V_LOWER, 20'd0);
    write_reg(cdss_pkg::REG_CPV, 20'd0);
    write_reg(cdss_pkg::REG_OFFSET, 20'd0);
    write_reg(cdss_pkg::REG_TERMS, 20'd2);
    write_reg(cdss_pkg::REG_TOL, 20'd1);
    for (int i = 0; i < 6; i++) send_target(rand_target());
    drain();
  endtask

  task automatic test_pressure;
    write_reg(cdss_pkg::REG_V_UPPER, 20'd32755);
    write_reg(cdss_pkg::REG_V_LOWER, 20'd2614);
    write_reg(cdss_pkg::REG_CPV, 20'd349947);
    write_reg(cdss_pkg::REG_OFFSET, 20'd2045);
    write_reg(cdss_pkg::REG_TERMS, 20'd11);
    write_reg(cdss_pkg::REG_TOL, 20'd8);
    rx_idle_enable = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 5; i++) send_target(rand_target());
    rx_idle_enable = 1;
    drain();
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(cdss_pkg::REG_V_UPPER, 20'($urandom_range(0, 65535)));
      write_reg(cdss_pkg::REG_V_LOWER, 20'($urandom_range(0, 65535)));
      write_reg(cdss_pkg::REG_CPV, 20'($urandom_range(1, 1048575)));
      write_reg(cdss_pkg::REG_OFFSET, 20'($urandom_range(0, 4095)));
      write_reg(cdss_pkg::REG_TERMS, 20'($urandom_range(2, 11)));
      write_reg(cdss_pkg::REG_TOL, 20'($urandom_range(0, 255)));
      if (phase == 4) begin
        tx_idle_enable = 0;
        rx_idle_enable = 0;
      end
      for (int i = 0; i < 120; i++) send_target(rand_target());
      drain();
    end
  endtask

  initial begin
    m_v_upper = 16'd32755;
    m_v_lower = 16'd2614;
    m_cpv = 20'd349947;
    m_offset = 12'd2045;
    m_terms = 4'd11;
    m_tol = 8'd8;
    for (int i = 0; i < TERM_LIMIT; i++) m_coeff[i] = cdss_pkg::curve_coeff(4'(i));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_corners();
    test_pressure();
    test_random();
    if (mismatches == 0 && pending_setpoints.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cdss_pkg.sv
hw/rtl/cdss_ctrl.sv
hw/rtl/cdss_dp.sv
hw/rtl/chebyshev_diode_setpoint_search_unit.sv
bench/testbench.sv
